FILE: rtl/core/kfpl_pkg.sv
// ----------------------------------------------------------------------------
// kfpl_pkg
// Shared types, widths, opcodes and the gamma table for the keyframe fade
// level generator.
// ----------------------------------------------------------------------------
package kfpl_pkg;

  localparam int KFPL_MAX_KEYS = 16;

  localparam int OP_W       = 2;
  localparam int DUR_W      = 16;
  localparam int LEVEL_W    = 8;
  localparam int TIME_W     = 20;
  localparam int MS_W       = 64;
  localparam int DUTY_W     = 10;
  localparam int IN_DATA_W  = DUR_W + LEVEL_W + MS_W;
  localparam int OUT_DATA_W = 32;

  localparam int PROD_W    = TIME_W + LEVEL_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int QUO_W     = LEVEL_W;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int MOD_STEPS = MS_W / 2;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);
  localparam int LVL_IDX_W = 7;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [DUTY_W-1:0]  DUTY_OFF  = 10'd1023;
  localparam logic [LEVEL_W-1:0] LEVEL_CAP = 8'd100;

  localparam logic [DUTY_W-1:0] GAMMA_TAB [0:100] = '{
    10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd1,
    10'd1,   10'd1,   10'd2,   10'd2,   10'd3,   10'd3,   10'd4,   10'd5,
    10'd6,   10'd7,   10'd8,   10'd10,  10'd11,  10'd13,  10'd15,  10'd17,
    10'd19,  10'd21,  10'd24,  10'd26,  10'd29,  10'd32,  10'd35,  10'd39,
    10'd42,  10'd46,  10'd50,  10'd54,  10'd59,  10'd63,  10'd68,  10'd73,
    10'd79,  10'd84,  10'd90,  10'd96,  10'd103, 10'd109, 10'd116, 10'd124,
    10'd131, 10'd139, 10'd147, 10'd155, 10'd164, 10'd173, 10'd182, 10'd192,
    10'd202, 10'd212, 10'd223, 10'd234, 10'd245, 10'd257, 10'd269, 10'd281,
    10'd293, 10'd307, 10'd320, 10'd334, 10'd348, 10'd362, 10'd377, 10'd392,
    10'd408, 10'd424, 10'd441, 10'd458, 10'd475, 10'd493, 10'd511, 10'd529,
    10'd548, 10'd568, 10'd587, 10'd608, 10'd628, 10'd650, 10'd671, 10'd693,
    10'd716, 10'd739, 10'd762, 10'd786, 10'd811, 10'd836, 10'd861, 10'd887,
    10'd913, 10'd940, 10'd968, 10'd996, 10'd1023
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_APP_WR,
    ST_MOD,
    ST_SCAN,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV,
    ST_OUT
  } kfpl_state_t;

  typedef struct packed {
    logic [TIME_W-1:0]  start;
    logic [LEVEL_W-1:0] level;
  } kfpl_key_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic app_rd;
    logic app_wr;
    logic mod_step;
    logic scan_step;
    logic mul_a;
    logic mul_b;
    logic div_step;
    logic out_load;
  } kfpl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            len_zero;
    logic            mod_last;
    logic            scan_done;
    logic            div_last;
    logic            out_free;
  } kfpl_sts_t;

endpackage

FILE: rtl/core/kfpl_ctrl.sv
// ----------------------------------------------------------------------------
// kfpl_ctrl
// Sequencer for the fade generator: decodes each word and steps the datapath
// through append, remainder, key scan, interpolation and division phases.
// ----------------------------------------------------------------------------
module kfpl_ctrl import kfpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  kfpl_sts_t sts,
  output kfpl_cmd_t cmd
);

  kfpl_state_t state_r;
  kfpl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_APPEND: state_nxt = ST_APP_WR;
          OP_TICK:   state_nxt = sts.len_zero ? ST_IDLE : ST_MOD;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_APP_WR: state_nxt = ST_IDLE;
      ST_MOD: begin
        if (sts.mod_last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_MUL_A;
      end
      ST_MUL_A: state_nxt = ST_MUL_B;
      ST_MUL_B: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_DECODE: begin
        cmd.clear  = (sts.op == OP_CLEAR);
        cmd.app_rd = (sts.op == OP_APPEND);
      end
      ST_APP_WR: cmd.app_wr    = 1'b1;
      ST_MOD:    cmd.mod_step  = 1'b1;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_MUL_A:  cmd.mul_a     = 1'b1;
      ST_MUL_B:  cmd.mul_b     = 1'b1;
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_OUT:    cmd.out_load  = sts.out_free;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/kfpl_dp.sv
// ----------------------------------------------------------------------------
// kfpl_dp
// Datapath of the fade generator: keyframe memory, offset register, radix-4
// remainder unit, key scan, interpolation multiplier, quotient unit and the
// output register.
// ----------------------------------------------------------------------------
module kfpl_dp import kfpl_pkg::*; #(
  parameter int MAX_KEYS = KFPL_MAX_KEYS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  cfg_wr_en,
  input  logic [MS_W-1:0]       cfg_wr_data,
  input  kfpl_cmd_t             cmd,
  output kfpl_sts_t             sts,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int IW = $clog2(MAX_KEYS);

  logic [MS_W-1:0]    off_r;
  logic [OP_W-1:0]    op_r;
  logic [DUR_W-1:0]   dur_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [CW-1:0]      cnt_r;
  logic [TIME_W-1:0]  len_r;

  kfpl_key_t key_mem_r [MAX_KEYS];
  kfpl_key_t key_q_r;

  logic [MS_W-1:0]      mod_div_r;
  logic [TIME_W-1:0]    mod_rem_r;
  logic [MOD_CNT_W-1:0] mod_cnt_r;

  logic [CW-1:0]      iss_r;
  logic               pend_r;
  logic               first_r;
  logic               stop_r;
  logic               found_r;
  logic [TIME_W-1:0]  lo_t_r;
  logic [LEVEL_W-1:0] lo_v_r;
  logic [TIME_W-1:0]  hi_t_r;
  logic [LEVEL_W-1:0] hi_v_r;

  logic [PROD_W-1:0]    prod_r;
  logic [TIME_W-1:0]    span_r;
  logic [ACC_W-1:0]     div_rem_r;
  logic [ACC_W-1:0]     div_dsr_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic               out_valid_r;
  logic [DUTY_W-1:0]  out_duty_r;
  logic [TIME_W-1:0]  out_phase_r;

  // Append decisions.
  logic              same_key;
  logic              has_room;
  logic              app_we;
  logic [IW-1:0]     last_idx;
  logic [IW-1:0]     wr_idx;
  logic [TIME_W:0]   len_sum;
  logic [TIME_W-1:0] len_sat;

  assign same_key = (cnt_r != '0) && (key_q_r.start == len_r);
  assign has_room = (cnt_r < CW'(MAX_KEYS));
  assign app_we   = cmd.app_wr && (same_key || has_room);
  assign last_idx = IW'(cnt_r - 1'b1);
  assign wr_idx   = same_key ? last_idx : IW'(cnt_r);
  assign len_sum  = {1'b0, len_r} + (TIME_W + 1)'(dur_r);
  assign len_sat  = len_sum[TIME_W] ? TIME_MAX : len_sum[TIME_W-1:0];

  // Key memory read port, shared by append and scan.
  logic          issue;
  logic          rd_en;
  logic [IW-1:0] rd_idx;

  assign issue  = (iss_r < cnt_r);
  assign rd_en  = cmd.app_rd || (cmd.scan_step && issue);
  assign rd_idx = cmd.app_rd ? last_idx : iss_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (app_we) begin
      key_mem_r[wr_idx] <= kfpl_key_t'({len_r, lvl_r});
    end
    if (rd_en) begin
      key_q_r <= key_mem_r[rd_idx];
    end
  end

  // Two remainder steps per cycle.
  logic [TIME_W:0]   r1;
  logic [TIME_W:0]   r1s;
  logic [TIME_W:0]   r2;
  logic [TIME_W:0]   r2s;
  logic [TIME_W-1:0] mod_rem_nxt;

  always_comb begin
    r1  = {mod_rem_r, mod_div_r[MS_W-1]};
    r1s = (r1 >= {1'b0, len_r}) ? (r1 - {1'b0, len_r}) : r1;
    r2  = {r1s[TIME_W-1:0], mod_div_r[MS_W-2]};
    r2s = (r2 >= {1'b0, len_r}) ? (r2 - {1'b0, len_r}) : r2;
    mod_rem_nxt = r2s[TIME_W-1:0];
  end

  // Neighbor search over the word that arrived from the key memory.
  logic               first_nxt;
  logic               stop_nxt;
  logic               found_nxt;
  logic [TIME_W-1:0]  lo_t_nxt;
  logic [LEVEL_W-1:0] lo_v_nxt;
  logic [TIME_W-1:0]  hi_t_nxt;
  logic [LEVEL_W-1:0] hi_v_nxt;

  always_comb begin
    first_nxt = first_r;
    stop_nxt  = stop_r;
    found_nxt = found_r;
    lo_t_nxt  = lo_t_r;
    lo_v_nxt  = lo_v_r;
    hi_t_nxt  = hi_t_r;
    hi_v_nxt  = hi_v_r;
    if (pend_r) begin
      first_nxt = 1'b0;
      if (first_r) hi_v_nxt = key_q_r.level;
      if (!stop_r) begin
        priority if (key_q_r.start >= len_r) begin
          stop_nxt = 1'b1;
        end else if (key_q_r.start <= mod_rem_r) begin
          lo_t_nxt = key_q_r.start;
          lo_v_nxt = key_q_r.level;
        end else if (!found_r) begin
          hi_t_nxt  = key_q_r.start;
          hi_v_nxt  = key_q_r.level;
          found_nxt = 1'b1;
        end
      end
    end
  end

  // Interpolation terms and quotient step.
  logic [TIME_W-1:0]    d_lo;
  logic [TIME_W-1:0]    d_hi;
  logic [PROD_W-1:0]    prod_b;
  logic                 q_bit;
  logic [LEVEL_W-1:0]   lv;
  logic [LVL_IDX_W-1:0] lv_idx;

  assign d_lo   = mod_rem_r - lo_t_r;
  assign d_hi   = hi_t_r - mod_rem_r;
  assign prod_b = PROD_W'(d_hi) * PROD_W'(lo_v_r);
  assign q_bit  = (div_rem_r >= div_dsr_r);
  assign lv     = (span_r == '0) ? lo_v_r : quo_r;
  assign lv_idx = (lv > LEVEL_CAP) ? LVL_IDX_W'(LEVEL_CAP) : lv[LVL_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= '0;
      cnt_r       <= '0;
      len_r       <= '0;
      mod_cnt_r   <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      stop_r      <= 1'b0;
      found_r     <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) off_r <= cfg_wr_data;

      if (cmd.clear) begin
        cnt_r <= '0;
        len_r <= '0;
      end else if (app_we) begin
        if (!same_key) cnt_r <= cnt_r + 1'b1;
        len_r <= len_sat;
      end

      if (cmd.take) begin
        mod_cnt_r <= '0;
        iss_r     <= '0;
        pend_r    <= 1'b0;
        first_r   <= 1'b1;
        stop_r    <= 1'b0;
        found_r   <= 1'b0;
      end else begin
        if (cmd.mod_step) mod_cnt_r <= mod_cnt_r + 1'b1;
        if (cmd.scan_step) begin
          iss_r   <= iss_r + CW'(issue);
          pend_r  <= issue;
          first_r <= first_nxt;
          stop_r  <= stop_nxt;
          found_r <= found_nxt;
        end
      end

      if (cmd.mul_b) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r      <= in_tuser;
      dur_r     <= in_tdata[DUR_W-1:0];
      lvl_r     <= in_tdata[DUR_W +: LEVEL_W];
      mod_div_r <= in_tdata[DUR_W + LEVEL_W +: MS_W] + off_r;
      mod_rem_r <= '0;
      lo_t_r    <= '0;
      lo_v_r    <= '0;
      hi_t_r    <= len_r;
      hi_v_r    <= '0;
    end else begin
      if (cmd.mod_step) begin
        mod_div_r <= mod_div_r << 2;
        mod_rem_r <= mod_rem_nxt;
      end
      if (cmd.scan_step) begin
        lo_t_r <= lo_t_nxt;
        lo_v_r <= lo_v_nxt;
        hi_t_r <= hi_t_nxt;
        hi_v_r <= hi_v_nxt;
      end
    end

    if (cmd.mul_a) begin
      prod_r <= PROD_W'(d_lo) * PROD_W'(hi_v_r);
      span_r <= hi_t_r - lo_t_r;
    end

    if (cmd.mul_b) begin
      div_rem_r <= ACC_W'(prod_r) + ACC_W'(prod_b) + ACC_W'(span_r >> 1);
      div_dsr_r <= ACC_W'(span_r) << (QUO_W - 1);
    end else if (cmd.div_step) begin
      if (q_bit) div_rem_r <= div_rem_r - div_dsr_r;
      div_dsr_r <= div_dsr_r >> 1;
      quo_r     <= {quo_r[QUO_W-2:0], q_bit};
    end

    if (cmd.out_load) begin
      out_duty_r  <= DUTY_OFF - GAMMA_TAB[lv_idx];
      out_phase_r <= mod_rem_r;
    end
  end

  assign sts.op        = op_r;
  assign sts.len_zero  = (len_r == '0);
  assign sts.mod_last  = (mod_cnt_r == MOD_CNT_W'(MOD_STEPS - 1));
  assign sts.scan_done = !issue && !pend_r;
  assign sts.div_last  = (div_cnt_r == DIV_CNT_W'(QUO_W - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - TIME_W - DUTY_W){1'b0}}, out_phase_r, out_duty_r};

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (cnt_r == '0 && len_r == '0))
    else $error("key store not emptied after clear");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.app_wr |=> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1'b1)
                   && cnt_r <= CW'(MAX_KEYS))
    else $error("key count stepped wrongly on append");

  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_step |=> (mod_rem_r < len_r))
    else $error("phase remainder not below cycle length");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before it was taken");

endmodule

FILE: rtl/core/keyframe_fade_pwm_level.sv
// ----------------------------------------------------------------------------
// keyframe_fade_pwm_level
// Looping LED fade generator with keyframe store, linear interpolation and
// inverted gamma-corrected PWM compare output.
// ----------------------------------------------------------------------------
// The block takes one word at a time. A clear word is handled in the decode
// state alone; an append word adds a write state after the registered read
// of the last key from the key memory. A tick word steps through decode, the
// two-bit-per-cycle remainder of the 64-bit time by the cycle length, a scan
// of the stored keyframes, the two interpolation products, the quotient and
// the result load. The result sits in an output register, so the next word
// is accepted while a result still waits to be taken; a tick only stalls at
// its end if the previous result is still held. Ticks with a zero cycle
// length and words with operation code 3 give no result.
// ----------------------------------------------------------------------------
module keyframe_fade_pwm_level import kfpl_pkg::*; #(
  parameter int MAX_KEYS = KFPL_MAX_KEYS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // duration, level, time_ms
  input  logic [OP_W-1:0]       in_tuser,    // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // duty, phase, zero fill
  input  logic                  cfg_wr_en,
  input  logic [MS_W-1:0]       cfg_wr_data
);

  kfpl_cmd_t cmd;
  kfpl_sts_t sts;

  kfpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kfpl_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

endmodule

FILE: verif/keyframe_fade_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_fade_monitor
// Watches the input, result and register ports of the keyframe fade level
// generator. It keeps its own keyframe store and time offset, works out the
// duty and phase that each accepted tick word with a nonzero cycle length must
// produce, and compares every accepted result word with the oldest prediction
// still waiting.
module keyframe_fade_monitor import kfpl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [MS_W-1:0]       cfg_wr_data,
  output int                    pending,
  output int                    errors,
  output int                    checked
);

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [TIME_W-1:0] phase;
  } pwm_sample_t;

  logic [TIME_W-1:0]  key_start [KFPL_MAX_KEYS];
  logic [LEVEL_W-1:0] key_level [KFPL_MAX_KEYS];
  int                 key_count = 0;
  logic [TIME_W-1:0]  cycle_len = '0;
  logic [MS_W-1:0]    time_offset = '0;
  pwm_sample_t        duty_q [$];
  pwm_sample_t        want;

  initial begin
    pending = 0;
    errors  = 0;
    checked = 0;
  end

  function automatic pwm_sample_t fade_sample(input logic [MS_W-1:0] now);
    logic [MS_W-1:0]    pos;
    logic [MS_W-1:0]    acc;
    logic [MS_W-1:0]    lv;
    logic [TIME_W-1:0]  ph, lo_t, hi_t, span;
    logic [LEVEL_W-1:0] lo_v, hi_v;
    bit                 found, past_end;
    pwm_sample_t        res;
    pos      = (now + time_offset) % MS_W'(cycle_len);
    ph       = pos[TIME_W-1:0];
    lo_t     = '0;
    lo_v     = '0;
    hi_t     = cycle_len;
    hi_v     = (key_count > 0) ? key_level[0] : '0;
    found    = 1'b0;
    past_end = 1'b0;
    for (int i = 0; i < key_count; i++) begin
      if (key_start[i] >= cycle_len) past_end = 1'b1;
      if (!past_end) begin
        if (key_start[i] <= ph) begin
          lo_t = key_start[i];
          lo_v = key_level[i];
        end else if (!found) begin
          hi_t  = key_start[i];
          hi_v  = key_level[i];
          found = 1'b1;
        end
      end
    end
    span = hi_t - lo_t;
    if (span == '0) begin
      lv = MS_W'(lo_v);
    end else begin
      acc = MS_W'(ph - lo_t) * MS_W'(hi_v) + MS_W'(hi_t - ph) * MS_W'(lo_v)
          + MS_W'(span / 2);
      lv  = acc / MS_W'(span);
    end
    if (lv > MS_W'(LEVEL_CAP)) lv = MS_W'(LEVEL_CAP);
    res.duty  = DUTY_OFF - GAMMA_TAB[int'(lv)];
    res.phase = ph;
    return res;
  endfunction

  task automatic fade_update(input logic [OP_W-1:0] op, input logic [DUR_W-1:0] dur,
                             input logic [LEVEL_W-1:0] lvl, input logic [MS_W-1:0] now);
    logic [TIME_W:0] t;
    bit              advance;
    case (op)
      OP_CLEAR: begin
        key_count = 0;
        cycle_len = '0;
      end
      OP_APPEND: begin
        advance = 1'b1;
        if (key_count > 0 && key_start[key_count-1] == cycle_len) begin
          key_level[key_count-1] = lvl;
        end else if (key_count < KFPL_MAX_KEYS) begin
          key_start[key_count] = cycle_len;
          key_level[key_count] = lvl;
          key_count++;
        end else begin
          advance = 1'b0;
        end
        if (advance) begin
          t = {1'b0, cycle_len} + {5'd0, dur};
          cycle_len = (t > {1'b0, TIME_MAX}) ? TIME_MAX : t[TIME_W-1:0];
        end
      end
      OP_TICK: begin
        if (cycle_len != '0) duty_q.push_back(fade_sample(now));
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_count   = 0;
      cycle_len   = '0;
      time_offset = '0;
      duty_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (duty_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result word: duty %0d phase %0d", $realtime,
                     out_tdata[DUTY_W-1:0], out_tdata[DUTY_W+:TIME_W]);
        end else begin
          want = duty_q.pop_front();
          checked++;
          if (out_tdata[DUTY_W-1:0] !== want.duty ||
              out_tdata[DUTY_W+:TIME_W] !== want.phase ||
              out_tdata[OUT_DATA_W-1:DUTY_W+TIME_W] !== '0) begin
            errors++;
            if (errors <= 10)
              $display("[%0t] mismatch: expected duty %0d phase %0d, got duty %0d phase %0d fill %0h",
                       $realtime, want.duty, want.phase, out_tdata[DUTY_W-1:0],
                       out_tdata[DUTY_W+:TIME_W], out_tdata[OUT_DATA_W-1:DUTY_W+TIME_W]);
          end
        end
      end
      if (in_tvalid && in_tready)
        fade_update(in_tuser, in_tdata[DUR_W-1:0], in_tdata[DUR_W+:LEVEL_W],
                    in_tdata[DUR_W+LEVEL_W+:MS_W]);
      if (cfg_wr_en) time_offset = cfg_wr_data;
    end
    pending = duty_q.size();
  end

endmodule

FILE: verif/tb_keyframe_fade_pwm_level.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_fade_pwm_level
// Drives the keyframe fade level generator with directed keyframe programs and
// ticks, then with random programs under several time offsets, with random
// gaps on both streams and one long output hold-off. A separate monitor
// predicts and checks every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_keyframe_fade_pwm_level;
  import kfpl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 800;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int NUM_PHASES = 6;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = OP_CLEAR;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [MS_W-1:0]       cfg_wr_data = '0;

  int              mon_pending, mon_errors, mon_checked;
  int              cycle_cnt = 0;
  int              words_sent = 0;
  int              ticks_sent = 0;
  int              approx_len = 0;
  bit              calm = 1'b0;
  bit              hold_req = 1'b0;
  logic [MS_W-1:0] cur_offset = '0;

  keyframe_fade_pwm_level DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  keyframe_fade_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .pending    (mon_pending),
    .errors     (mon_errors),
    .checked    (mon_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Run did not complete within %0d cycles.", LIMIT_CYCLES);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic int pick_dur();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 0;
    if (r < 50) return $urandom_range(1, 50);
    if (r < 80) return $urandom_range(51, 2000);
    if (r < 92) return $urandom_range(0, 65535);
    return 65535;
  endfunction

  function automatic int pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 100);
    if (r < 80) return ($urandom_range(0, 1) != 0) ? 100 : 0;
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [MS_W-1:0] pick_time(input int len);
    int              r;
    logic [MS_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 40) return {$urandom, $urandom};
    if (r < 70) return MS_W'($urandom_range(0, 3 * len + 2));
    if (r < 85) begin
      k = MS_W'($urandom_range(0, 1000));
      return k * MS_W'(len) + MS_W'($urandom_range(0, 2)) - 1 - cur_offset;
    end
    return '1 - MS_W'($urandom_range(0, len));
  endfunction

  // The sender keeps the word on the bus until it is taken.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [DUR_W-1:0] dur,
                           input logic [LEVEL_W-1:0] lvl, input logic [MS_W-1:0] now);
    int g;
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      if (g > 1) repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tuser  = op;
    in_tdata  = {now, lvl, dur};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (op != OP_UNUSED) words_sent++;
    if (op == OP_TICK) ticks_sent++;
  endtask

  task automatic send_append(input int dur, input int lvl);
    send_word(OP_APPEND, DUR_W'(dur), LEVEL_W'(lvl), {$urandom, $urandom});
  endtask

  task automatic send_tick(input logic [MS_W-1:0] now);
    send_word(OP_TICK, DUR_W'($urandom_range(0, 65535)), LEVEL_W'($urandom_range(0, 255)), now);
  endtask

  task automatic send_clear();
    send_word(OP_CLEAR, DUR_W'($urandom_range(0, 65535)), LEVEL_W'($urandom_range(0, 255)),
              {$urandom, $urandom});
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (mon_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_offset(input logic [MS_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cur_offset  = value;
  endtask

  task automatic run_programs(input int n_items);
    int done, nkeys, nticks, dur;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 9) != 0) begin
        send_clear();
        approx_len = 0;
        done++;
      end
      nkeys = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 6);
      for (int k = 0; k < nkeys; k++) begin
        dur = pick_dur();
        send_append(dur, pick_level());
        approx_len += dur;
        done++;
        if ($urandom_range(0, 29) == 0)
          send_word(OP_UNUSED, DUR_W'($urandom_range(0, 65535)),
                    LEVEL_W'($urandom_range(0, 255)), {$urandom, $urandom});
      end
      nticks = $urandom_range(1, 8);
      for (int k = 0; k < nticks; k++) begin
        send_tick(pick_time(approx_len));
        done++;
      end
    end
  endtask

  initial begin
    int g, held;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        out_tready = 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
      end else if (calm) begin
        out_tready = 1'b1;
      end else begin
        g = pick_gap();
        out_tready = (g == 0);
        if (g > 1) repeat (g - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic [MS_W-1:0] offset_val;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed program under the reset offset.
    send_tick('0);
    send_word(OP_UNUSED, '1, '1, '1);
    send_append(0, 50);
    send_append(1000, 255);
    send_append(3000, 0);
    send_append(0, 100);
    send_tick(64'd0);
    send_tick(64'd999);
    send_tick(64'd1000);
    send_tick(64'd2500);
    send_tick(64'd3999);
    send_tick(64'd4000);
    send_tick('1);
    send_clear();
    send_tick(64'd12345);
    send_append(65535, 0);
    send_append(1, 100);
    send_tick('1);
    send_tick(64'd65535);
    send_word(OP_UNUSED, '0, '0, '0);
    send_tick(64'd65536);
    drain_block();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: offset_val = '1;
        1: offset_val = {$urandom, $urandom};
        2: offset_val = '0;
        3: offset_val = 64'h8000_0000_0000_0000;
        4: offset_val = MS_W'($urandom_range(0, 5000));
        default: offset_val = {$urandom, $urandom};
      endcase
      write_offset(offset_val);
      calm = (p == 2 || p == 5);
      if (p == 1) begin
        // Back-to-back ticks while the result side holds off fill the block.
        calm = 1'b1;
        send_clear();
        send_append(100, 30);
        send_append(200, 90);
        approx_len = 300;
        hold_req = 1'b1;
        repeat (10) send_tick(pick_time(approx_len));
        calm = 1'b0;
      end
      run_programs(ITEMS_PER_PHASE);
      drain_block();
    end

    $display("Covered %0d words, %0d of them ticks, over %0d register settings.",
             words_sent, ticks_sent, NUM_PHASES + 1);
    $display("Compared %0d result words; %0d mismatches.", mon_checked, mon_errors);
    if (mon_errors == 0 && mon_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
